[hw/rtl/baro_pkg.sv]
`timescale 1ns / 1ps

package baro_pkg;

    // Field and datapath widths.
    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int IDX_W      = 3;
    localparam int DT_W       = 25;
    localparam int TEMP_W     = 20;
    localparam int DIFF5_W    = 23;
    localparam int T2_W       = 17;
    localparam int OFF_W      = 37;
    localparam int SENS_W     = 36;
    localparam int SENS_LO_W  = 18;
    localparam int MUL_W      = 26;
    localparam int PROD_W     = 52;
    localparam int SUM_W      = 44;
    localparam int X_W        = 42;
    localparam int P_W        = 27;
    localparam int TEMP_OUT_W = 15;
    localparam int PRES_OUT_W = 17;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_SENS     = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET   = 3'd1;
    localparam logic [IDX_W-1:0] REG_TCS      = 3'd2;
    localparam logic [IDX_W-1:0] REG_TCO      = 3'd3;
    localparam logic [IDX_W-1:0] REG_TREF     = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEMPSENS = 3'd5;

    // Sequencer steps.
    typedef logic [3:0] t_step;
    localparam t_step ST_IDLE  = 4'd0;
    localparam t_step ST_MTEMP = 4'd1;
    localparam t_step ST_MOFF  = 4'd2;
    localparam t_step ST_MSENS = 4'd3;
    localparam t_step ST_MDT2  = 4'd4;
    localparam t_step ST_MSQ   = 4'd5;
    localparam t_step ST_CORR  = 4'd6;
    localparam t_step ST_MPL   = 4'd7;
    localparam t_step ST_MPH   = 4'd8;
    localparam t_step ST_SUM   = 4'd9;
    localparam t_step ST_DONE  = 4'd10;

    typedef struct packed {
        logic  ready;
        t_step step;
        logic  finish;
    } t_seq_ctrl;

    // Reference temperature and saturation bounds.
    localparam logic signed [TEMP_W-1:0] TEMP_REF = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_LO  = -20'sd4000;
    localparam logic signed [TEMP_W-1:0] TEMP_HI  = 20'sd8500;
    localparam logic signed [P_W-1:0]    PRES_LO  = 27'sd1000;
    localparam logic signed [P_W-1:0]    PRES_HI  = 27'sd120000;

endpackage

[hw/rtl/baro_mul.sv]
`timescale 1ns / 1ps

module baro_mul
    import baro_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // Product is registered so that the next step sees a clean value.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/baro_seq.sv]
`timescale 1ns / 1ps

module baro_seq
    import baro_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_out_free,
    output t_seq_ctrl o_ctrl
);

    t_step r_state;
    t_step n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_MTEMP;
                end
            end
            ST_MTEMP: n_state = ST_MOFF;
            ST_MOFF:  n_state = ST_MSENS;
            ST_MSENS: n_state = ST_MDT2;
            ST_MDT2:  n_state = ST_MSQ;
            ST_MSQ:   n_state = ST_CORR;
            ST_CORR:  n_state = ST_MPL;
            ST_MPL:   n_state = ST_MPH;
            ST_MPH:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_DONE;
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctrl.ready  = (r_state == ST_IDLE);
    assign o_ctrl.step   = r_state;
    assign o_ctrl.finish = (r_state == ST_DONE) && i_out_free;

endmodule

[hw/rtl/barometer_compensation.sv]
`timescale 1ns / 1ps

// Sequencing: one item at a time, taken only in the idle step: seven steps on one shared 26x26
// multiplier, one correction, one summing and one output step, then the idle step takes the next input;
// a result that has not been taken yet holds the sequencer in its output step.
// Reset: i_rst_n is synchronous and active low; it clears the calibration registers, the
// stored raw readings, the sequencer and the output valid flag.
module barometer_compensation
    import baro_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [IDX_W-1:0]             i_cfg_index,
    input  logic [CAL_W-1:0]             i_cfg_data,
    // Raw reading input channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_action,
    input  logic [RAW_W-1:0]             i_raw_value,
    // Compensated result output channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [TEMP_OUT_W-1:0] o_temp_centi_c,
    output logic [PRES_OUT_W-1:0]        o_pressure_pa
);

    // Calibration coefficients C1..C6.
    logic [CAL_W-1:0] r_cal_sens;
    logic [CAL_W-1:0] r_cal_offset;
    logic [CAL_W-1:0] r_cal_tcs;
    logic [CAL_W-1:0] r_cal_tco;
    logic [CAL_W-1:0] r_cal_tref;
    logic [CAL_W-1:0] r_cal_tempsens;

    // Latest raw pressure (D1) and temperature (D2) readings.
    logic [RAW_W-1:0] r_last_p;
    logic [RAW_W-1:0] r_last_t;

    // Working registers of the compensation.
    logic signed [DT_W-1:0]   r_dt;
    logic signed [TEMP_W-1:0] r_temp;
    logic signed [OFF_W-1:0]  r_off;
    logic signed [SENS_W-1:0] r_sens;
    logic [T2_W-1:0]          r_t2;
    logic                     r_cold;
    logic [RAW_W-1:0]         r_lo;
    logic signed [X_W-1:0]    r_x;

    // Output register.
    logic                         r_out_valid;
    logic signed [TEMP_OUT_W-1:0] r_temp_out;
    logic [PRES_OUT_W-1:0]        r_pres_out;

    t_seq_ctrl                w_ctrl;
    logic                     w_accept;
    logic                     w_out_free;
    logic [RAW_W-1:0]         w_dt_src;
    logic signed [DT_W-1:0]   w_dt_new;
    logic signed [TEMP_W-1:0] w_diff;
    logic signed [DIFF5_W-1:0] w_diff5;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [P_W-1:0]    w_p;
    logic signed [TEMP_W-1:0] w_temp_sat;
    logic signed [P_W-1:0]    w_p_sat;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_ctrl.ready;
    assign w_accept    = i_in_valid && w_ctrl.ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    baro_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    baro_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // The temperature difference dT is formed in the transfer cycle itself, from the
    // incoming value when the item is a temperature reading.
    assign w_dt_src = i_action ? i_raw_value : r_last_t;
    assign w_dt_new = $signed({1'b0, w_dt_src}) - $signed({1'b0, r_cal_tref, 8'b0});

    // Distance below 20.00 C and five times it, for the second-order square term.
    assign w_diff  = r_temp - TEMP_REF;
    assign w_diff5 = (DIFF5_W'(w_diff) <<< 2) + DIFF5_W'(w_diff);

    // Operand selection for the shared multiplier. Each step issues one product, which
    // the following step consumes. D1 times SENS is split into a low half of 18 unsigned
    // bits and a signed high half so that both partial products fit the multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (w_ctrl.step)
            ST_MTEMP: begin
                w_mul_a = MUL_W'(r_dt);
                w_mul_b = $signed(MUL_W'(r_cal_tempsens));
            end
            ST_MOFF: begin
                w_mul_a = MUL_W'(r_dt);
                w_mul_b = $signed(MUL_W'(r_cal_tco));
            end
            ST_MSENS: begin
                w_mul_a = MUL_W'(r_dt);
                w_mul_b = $signed(MUL_W'(r_cal_tcs));
            end
            ST_MDT2: begin
                w_mul_a = MUL_W'(r_dt);
                w_mul_b = MUL_W'(r_dt);
            end
            ST_MSQ: begin
                w_mul_a = MUL_W'(w_diff5);
                w_mul_b = MUL_W'(w_diff);
            end
            ST_MPL: begin
                w_mul_a = $signed(MUL_W'(r_last_p));
                w_mul_b = $signed(MUL_W'(r_sens[SENS_LO_W-1:0]));
            end
            ST_MPH: begin
                w_mul_a = $signed(MUL_W'(r_last_p));
                w_mul_b = MUL_W'($signed(r_sens[SENS_W-1:SENS_LO_W]));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Since the low partial product is never negative, flooring it by 2^18 first and then
    // flooring the sum by 2^3 gives the same result as flooring the full product by 2^21.
    assign w_sum = SUM_W'(w_prod) + $signed(SUM_W'(r_lo));

    // Final pressure and saturation of both results.
    assign w_p = P_W'(r_x >>> 15);

    always_comb begin
        if (r_temp < TEMP_LO) begin
            w_temp_sat = TEMP_LO;
        end else if (r_temp > TEMP_HI) begin
            w_temp_sat = TEMP_HI;
        end else begin
            w_temp_sat = r_temp;
        end
        if (w_p < PRES_LO) begin
            w_p_sat = PRES_LO;
        end else if (w_p > PRES_HI) begin
            w_p_sat = PRES_HI;
        end else begin
            w_p_sat = w_p;
        end
    end

    // Configuration registers and stored raw readings.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_sens     <= '0;
            r_cal_offset   <= '0;
            r_cal_tcs      <= '0;
            r_cal_tco      <= '0;
            r_cal_tref     <= '0;
            r_cal_tempsens <= '0;
            r_last_p       <= '0;
            r_last_t       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SENS:     r_cal_sens     <= i_cfg_data;
                    REG_OFFSET:   r_cal_offset   <= i_cfg_data;
                    REG_TCS:      r_cal_tcs      <= i_cfg_data;
                    REG_TCO:      r_cal_tco      <= i_cfg_data;
                    REG_TREF:     r_cal_tref     <= i_cfg_data;
                    REG_TEMPSENS: r_cal_tempsens <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                if (i_action) begin
                    r_last_t <= i_raw_value;
                end else begin
                    r_last_p <= i_raw_value;
                end
            end
        end
    end

    // Compensation datapath. The first-order TEMP, OFF and SENS are built one product at
    // a time; the second-order correction is applied in one step when TEMP is below
    // 20.00 C, and then D1 times SENS is summed from its two partial products.
    always_ff @(posedge i_clk) begin
        case (w_ctrl.step)
            ST_IDLE: begin
                if (w_accept) begin
                    r_dt <= w_dt_new;
                end
            end
            ST_MOFF: begin
                r_temp <= TEMP_REF + TEMP_W'(w_prod >>> 23);
            end
            ST_MSENS: begin
                r_off <= $signed(OFF_W'({r_cal_offset, 16'b0})) + OFF_W'(w_prod >>> 7);
            end
            ST_MDT2: begin
                r_sens <= $signed(SENS_W'({r_cal_sens, 15'b0})) + SENS_W'(w_prod >>> 8);
            end
            ST_MSQ: begin
                r_t2   <= w_prod[47:31];
                r_cold <= (r_temp < TEMP_REF);
            end
            ST_CORR: begin
                if (r_cold) begin
                    r_temp <= r_temp - $signed(TEMP_W'(r_t2));
                    r_off  <= r_off - OFF_W'(w_prod >>> 1);
                    r_sens <= r_sens - SENS_W'(w_prod >>> 2);
                end
            end
            ST_MPH: begin
                r_lo <= w_prod[41:18];
            end
            ST_SUM: begin
                r_x <= X_W'(w_sum >>> 3) - X_W'(r_off);
            end
            default: ;
        endcase
    end

    // Output register: it holds a finished result until its transfer, while the
    // sequencer is already free to take the next reading.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.finish) begin
            r_temp_out <= TEMP_OUT_W'(w_temp_sat);
            r_pres_out <= w_p_sat[PRES_OUT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_temp_centi_c = r_temp_out;
    assign o_pressure_pa  = r_pres_out;

    // After an input transfer the block stays busy until the result is formed.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input accepted while a reading was still being compensated");

    // A new result only appears from the final sequencer step.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctrl.step) == ST_DONE)
        else $error("output valid raised outside the final step");

    // Delivered results always lie within the saturation bounds.
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_temp_centi_c >= -15'sd4000) && (o_temp_centi_c <= 15'sd8500))
        else $error("temperature result outside its saturation range");

    a_pres_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pressure_pa >= 17'd1000) && (o_pressure_pa <= 17'd120000))
        else $error("pressure result outside its saturation range");

endmodule
